[design/assert_macros.svh]
// Assertion macros used by the checker module of this project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[design/cmsb_pkg.sv]
// Types and constants of the clipped mono sprite blitter.
`default_nettype none

package cmsb_pkg;

  localparam int unsigned CoordW = 12;
  localparam int unsigned SizeW  = 8;
  localparam int unsigned PixW   = 8;
  localparam int unsigned ColorW = 8;
  localparam int unsigned AddrW  = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 12;
  // Screen coordinate: origin plus image position, signed.
  localparam int unsigned ScrW   = CoordW + 1;
  // Row times screen width plus column, before truncation to the address width.
  localparam int unsigned ProdW  = 26;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_ORIGIN_X     = 3'd0,
    CFG_ORIGIN_Y     = 3'd1,
    CFG_IMAGE_WIDTH  = 3'd2,
    CFG_IMAGE_HEIGHT = 3'd3,
    CFG_DRAW_COLOR   = 3'd4
  } cfg_reg_e;

  localparam logic [CoordW-1:0] OriginReset = '0;
  localparam logic [SizeW-1:0]  WidthReset  = 8'd4;
  localparam logic [SizeW-1:0]  HeightReset = 8'd5;
  localparam logic [ColorW-1:0] ColorReset  = 8'd255;
  localparam logic [PixW-1:0]   PixFg       = 8'd1;

endpackage

`default_nettype wire

[design/clipped_mono_sprite_blit.sv]
// Clipped one-bit sprite blitter: image pixels in, frame buffer writes out.
//
//   channel   direction  handshake                 payload
//   input     in         in_valid_i / in_stall_o   pixel_value_i
//   output    out        out_valid_o / out_stall_i write_enable_o, write_address_o,
//                                                  write_data_o, image_done_o
//   config    in         cfg_we_i                  cfg_index_i, cfg_data_i
//
// One item per cycle while the output does not stall; results pass both stage registers.
// The first stage adds the origin and clips, the second multiplies the row by
// the screen width and adds the column.
// Reset clears the image counters and pipeline valids and loads the config reset values.
// A stall on the output holds the result register; input stalls only when both
// stages are full and the result is not taken.
`default_nettype none

module clipped_mono_sprite_blit #(
  parameter int unsigned SCREEN_WIDTH  = 1024,
  parameter int unsigned SCREEN_HEIGHT = 768
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [cmsb_pkg::PixW-1:0]     pixel_value_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic                               write_enable_o,
  output logic [cmsb_pkg::AddrW-1:0]         write_address_o,
  output logic [cmsb_pkg::ColorW-1:0]        write_data_o,
  output logic                               image_done_o,
  input  wire logic                          cfg_we_i,
  input  wire logic [cmsb_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [cmsb_pkg::CfgDataW-1:0] cfg_data_i
);
  import cmsb_pkg::*;

  localparam logic [ScrW:0] ScreenWLim = (ScrW+1)'(SCREEN_WIDTH);
  localparam logic [ScrW:0] ScreenHLim = (ScrW+1)'(SCREEN_HEIGHT);

  // Configuration registers.
  logic [CoordW-1:0] origin_x_q, origin_y_q;
  logic [SizeW-1:0]  image_width_q, image_height_q;
  logic [ColorW-1:0] draw_color_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      origin_x_q     <= OriginReset;
      origin_y_q     <= OriginReset;
      image_width_q  <= WidthReset;
      image_height_q <= HeightReset;
      draw_color_q   <= ColorReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_ORIGIN_X:     origin_x_q     <= cfg_data_i;
        CFG_ORIGIN_Y:     origin_y_q     <= cfg_data_i;
        CFG_IMAGE_WIDTH:  image_width_q  <= cfg_data_i[SizeW-1:0];
        CFG_IMAGE_HEIGHT: image_height_q <= cfg_data_i[SizeW-1:0];
        CFG_DRAW_COLOR:   draw_color_q   <= cfg_data_i[ColorW-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline handshake.
  logic s1_valid_q, s2_valid_q;
  logic s1_adv, s2_adv, in_acc;

  assign s2_adv     = !s2_valid_q || !out_stall_i;
  assign s1_adv     = !s1_valid_q || s2_adv;
  assign in_stall_o = !s1_adv;
  assign in_acc     = in_valid_i && s1_adv;

  // Image position counters.
  logic [SizeW-1:0] col_q, row_q, col_d, row_d;
  logic [SizeW-1:0] last_col, last_row;
  logic             col_last, done;

  always_comb begin
    last_col = image_width_q - SizeW'(1);
    last_row = image_height_q - SizeW'(1);
    col_last = (col_q == last_col);
    done     = col_last && (row_q == last_row);
    col_d    = col_last ? '0 : col_q + SizeW'(1);
    row_d    = row_q;
    if (col_last) begin
      row_d = done ? '0 : row_q + SizeW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else if (in_acc) begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

  // Stage 1: screen position and clipping.
  logic signed [ScrW-1:0] sx, sy;
  logic                   on_screen;

  always_comb begin
    sx = $signed({origin_x_q[CoordW-1], origin_x_q}) + $signed({5'b0, col_q});
    sy = $signed({origin_y_q[CoordW-1], origin_y_q}) + $signed({5'b0, row_q});
    on_screen = !sx[ScrW-1] && ({1'b0, sx} < ScreenWLim) &&
                !sy[ScrW-1] && ({1'b0, sy} < ScreenHLim);
  end

  logic [CoordW-1:0] s1_sx_q, s1_sy_q;
  logic              s1_on_q, s1_fg_q, s1_done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_adv) begin
      s1_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_sx_q   <= sx[CoordW-1:0];
      s1_sy_q   <= sy[CoordW-1:0];
      s1_on_q   <= on_screen;
      s1_fg_q   <= (pixel_value_i == PixFg);
      s1_done_q <= done;
    end
  end

  // Stage 2: frame buffer address and data.
  logic [ProdW-1:0]  addr_full;
  logic [AddrW-1:0]  addr_d;
  logic [ColorW-1:0] data_d;

  always_comb begin
    addr_full = ProdW'(s1_sy_q) * ProdW'(SCREEN_WIDTH) + ProdW'(s1_sx_q);
    addr_d    = s1_on_q ? addr_full[AddrW-1:0] : '0;
    data_d    = (s1_on_q && s1_fg_q) ? draw_color_q : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else if (s2_adv) begin
      s2_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_adv && s1_valid_q) begin
      write_enable_o  <= s1_on_q;
      write_address_o <= addr_d;
      write_data_o    <= data_d;
      image_done_o    <= s1_done_q;
    end
  end

  assign out_valid_o = s2_valid_q;

endmodule

`default_nettype wire

[design/cmsb_checker.sv]
// Port-level assertions for the clipped mono sprite blitter, bound to the top.
`default_nettype none

`include "assert_macros.svh"

module cmsb_checker #(
  parameter int unsigned SCREEN_WIDTH  = 1024,
  parameter int unsigned SCREEN_HEIGHT = 768
) (
  input wire logic                      clk_i,
  input wire logic                      rst_ni,
  input wire logic                      out_valid_o,
  input wire logic                      out_stall_i,
  input wire logic                      write_enable_o,
  input wire logic [cmsb_pkg::AddrW-1:0] write_address_o,
  input wire logic [cmsb_pkg::ColorW-1:0] write_data_o,
  input wire logic                      image_done_o
);
  import cmsb_pkg::*;

  // Addresses stay inside the frame buffer unless it exceeds the address space.
  localparam longint unsigned FbSize  = longint'(SCREEN_WIDTH) * longint'(SCREEN_HEIGHT);
  localparam longint unsigned AddrSpc = longint'(1) << AddrW;
  localparam logic [AddrW:0]  AddrLim = (AddrW+1)'((FbSize < AddrSpc) ? FbSize : AddrSpc);

  // A clipped pixel carries neither an address nor data.
  `ASSERT_IMPL(a_clip_zero, clk_i, rst_ni, out_valid_o && !write_enable_o,
               write_address_o == '0 && write_data_o == '0, "clipped item has payload")

  `ASSERT_IMPL(a_addr_range, clk_i, rst_ni, out_valid_o && write_enable_o,
               {1'b0, write_address_o} < AddrLim, "write address beyond frame buffer")

  `ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i,
               out_valid_o && $stable(write_enable_o) && $stable(write_address_o) &&
               $stable(write_data_o) && $stable(image_done_o), "stalled result changed")

endmodule

bind clipped_mono_sprite_blit cmsb_checker #(
  .SCREEN_WIDTH (SCREEN_WIDTH),
  .SCREEN_HEIGHT(SCREEN_HEIGHT)
) u_cmsb_checker (.*);

`default_nettype wire

[tb/sv/clipped_mono_sprite_blit_tb.sv]
// Self-checking testbench for the clipped mono sprite blitter.
`default_nettype none

module clipped_mono_sprite_blit_tb;
  import cmsb_pkg::*;

  localparam int SCREEN_W    = 1024;
  localparam int SCREEN_H    = 768;
  localparam int NUM_ITEMS   = 1350;
  localparam int CALM_ITEMS  = 150;
  localparam int HOLD_CYCLES = 40;
  localparam int NDIR        = 43;

  typedef struct packed {
    logic               we;
    logic [AddrW-1:0]   addr;
    logic [ColorW-1:0]  data;
    logic               done;
  } fb_write_t;

  typedef enum logic [1:0] {ROW_PIX, ROW_KNOWN, ROW_REG} row_kind_e;

  typedef struct packed {
    row_kind_e           kind;
    cfg_reg_e            sel;
    logic [CfgDataW-1:0] value;
    logic [PixW-1:0]     pix;
    fb_write_t           known;
  } dir_row_t;

  localparam fb_write_t RES_NONE     = '0;
  localparam fb_write_t CLIPPED_LAST = '{1'b0, '0, '0, 1'b1};

  logic                clk_i;
  logic                rst_ni;
  logic                in_valid_i;
  logic                in_stall_o;
  logic [PixW-1:0]     pixel_value_i;
  logic                out_valid_o;
  logic                out_stall_i;
  logic                write_enable_o;
  logic [AddrW-1:0]    write_address_o;
  logic [ColorW-1:0]   write_data_o;
  logic                image_done_o;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_index_i;
  logic [CfgDataW-1:0] cfg_data_i;

  clipped_mono_sprite_blit #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_value_i  (pixel_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .write_enable_o (write_enable_o),
    .write_address_o(write_address_o),
    .write_data_o   (write_data_o),
    .image_done_o   (image_done_o),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i)
  );

  // Blitter state as the predictor sees it.
  logic [CoordW-1:0] org_x = OriginReset;
  logic [CoordW-1:0] org_y = OriginReset;
  logic [SizeW-1:0]  img_w = WidthReset;
  logic [SizeW-1:0]  img_h = HeightReset;
  logic [ColorW-1:0] color = ColorReset;
  logic [SizeW-1:0]  col_cnt = '0;
  logic [SizeW-1:0]  row_cnt = '0;

  fb_write_t pending_writes[$];
  int        mismatches   = 0;
  int        items_sent   = 0;
  int        cfg_writes   = 0;
  int        images_done  = 0;
  int        writes_made  = 0;
  int        clipped      = 0;
  int        input_stalls = 0;
  logic      calm;
  logic      hold_tog;

  // Directed rows: after reset, screen edges, origin extremes, color masking.
  dir_row_t directed_rows [NDIR] = '{
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, '{1'b1, 20'h0, 8'hFF, 1'b0}},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'hFF, '{1'b1, 20'h1, 8'h00, 1'b0}},
    '{ROW_PIX,   CFG_ORIGIN_X,     12'h000, 8'h02, RES_NONE},
    '{ROW_PIX,   CFG_ORIGIN_X,     12'h000, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_IMAGE_WIDTH,  12'h001, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_IMAGE_HEIGHT, 12'h002, 8'h00, RES_NONE},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, '{1'b1, 20'h400, 8'hFF, 1'b1}},
    '{ROW_REG,   CFG_IMAGE_HEIGHT, 12'h001, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_ORIGIN_X,     12'h800, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_ORIGIN_Y,     12'h800, 8'h00, RES_NONE},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, CLIPPED_LAST},
    '{ROW_REG,   CFG_ORIGIN_X,     12'h7FF, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_ORIGIN_Y,     12'h000, 8'h00, RES_NONE},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, CLIPPED_LAST},
    '{ROW_REG,   CFG_ORIGIN_X,     12'h3FF, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_ORIGIN_Y,     12'h2FF, 8'h00, RES_NONE},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, '{1'b1, 20'hBFFFF, 8'hFF, 1'b1}},
    '{ROW_REG,   CFG_ORIGIN_X,     12'h400, 8'h00, RES_NONE},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, CLIPPED_LAST},
    '{ROW_REG,   CFG_ORIGIN_X,     12'h000, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_ORIGIN_Y,     12'h300, 8'h00, RES_NONE},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, CLIPPED_LAST},
    '{ROW_REG,   CFG_ORIGIN_Y,     12'hFFF, 8'h00, RES_NONE},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, CLIPPED_LAST},
    '{ROW_REG,   CFG_ORIGIN_Y,     12'h000, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_ORIGIN_X,     12'hFFF, 8'h00, RES_NONE},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, CLIPPED_LAST},
    '{ROW_REG,   CFG_ORIGIN_X,     12'h000, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_DRAW_COLOR,   12'hA00, 8'h00, RES_NONE},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, '{1'b1, 20'h0, 8'h00, 1'b1}},
    '{ROW_REG,   CFG_DRAW_COLOR,   12'h5A5, 8'h00, RES_NONE},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h01, '{1'b1, 20'h0, 8'hA5, 1'b1}},
    '{ROW_KNOWN, CFG_ORIGIN_X,     12'h000, 8'h81, '{1'b1, 20'h0, 8'h00, 1'b1}},
    '{ROW_REG,   CFG_IMAGE_WIDTH,  12'h003, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_IMAGE_HEIGHT, 12'h002, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_ORIGIN_X,     12'h3FE, 8'h00, RES_NONE},
    '{ROW_REG,   CFG_ORIGIN_Y,     12'h2FE, 8'h00, RES_NONE},
    '{ROW_PIX,   CFG_ORIGIN_X,     12'h000, 8'h01, RES_NONE},
    '{ROW_PIX,   CFG_ORIGIN_X,     12'h000, 8'h7E, RES_NONE},
    '{ROW_PIX,   CFG_ORIGIN_X,     12'h000, 8'h01, RES_NONE},
    '{ROW_PIX,   CFG_ORIGIN_X,     12'h000, 8'h01, RES_NONE},
    '{ROW_PIX,   CFG_ORIGIN_X,     12'h000, 8'h80, RES_NONE},
    '{ROW_PIX,   CFG_ORIGIN_X,     12'h000, 8'h01, RES_NONE}
  };

  // Works out the frame buffer write for one pixel and advances the counters.
  function automatic fb_write_t predict_blit(input logic [PixW-1:0] pix);
    int              sx;
    int              sy;
    logic [SizeW-1:0] last_col;
    logic [SizeW-1:0] last_row;
    fb_write_t       r;
    sx = int'($signed(org_x)) + int'(col_cnt);
    sy = int'($signed(org_y)) + int'(row_cnt);
    r = '0;
    if (sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H) begin
      r.we   = 1'b1;
      r.addr = AddrW'(sy * SCREEN_W + sx);
      r.data = (pix == PixFg) ? color : '0;
    end
    // A size of zero wraps to a last index of 255.
    last_col = img_w - 8'd1;
    last_row = img_h - 8'd1;
    if (col_cnt == last_col) begin
      col_cnt = '0;
      if (row_cnt == last_row) begin
        row_cnt = '0;
        r.done  = 1'b1;
      end else begin
        row_cnt = row_cnt + 8'd1;
      end
    end else begin
      col_cnt = col_cnt + 8'd1;
    end
    return r;
  endfunction

  // Items left in the current image; counters past the end count as a new image.
  function automatic int items_to_finish();
    logic [SizeW-1:0] lc;
    logic [SizeW-1:0] lr;
    lc = img_w - 8'd1;
    lr = img_h - 8'd1;
    if ((col_cnt != 0 || row_cnt != 0) && col_cnt <= lc && row_cnt <= lr)
      return (int'(lr) - int'(row_cnt)) * (int'(lc) + 1) + int'(lc) - int'(col_cnt) + 1;
    return (int'(lc) + 1) * (int'(lr) + 1);
  endfunction

  function automatic logic [CoordW-1:0] pick_origin(input int span, input int screen);
    int v;
    case ($urandom_range(0, 4))
      0: v = int'($urandom_range(0, 4095));
      1: v = int'($urandom_range(0, span + 8)) - span - 4;
      2: v = screen - span + int'($urandom_range(0, 8)) - 4;
      3: v = int'($urandom_range(0, screen - 1));
      default: v = ($urandom_range(0, 1) != 0) ? -2048 : 2047;
    endcase
    return CoordW'(v);
  endfunction

  function automatic logic [PixW-1:0] rand_pixel();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return PixFg;
    if (r < 55) return '0;
    return PixW'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(input logic [PixW-1:0] pix, input logic use_known,
                            input fb_write_t known);
    fb_write_t pred;
    in_valid_i    <= 1'b1;
    pixel_value_i <= pix;
    do @(posedge clk_i); while (in_stall_o);
    pred = predict_blit(pix);
    pending_writes.push_back(use_known ? known : pred);
    items_sent++;
    if (items_sent >= NUM_ITEMS - CALM_ITEMS) calm <= 1'b1;
    if (!calm && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end else if (!calm && $urandom_range(0, 149) == 0) begin
      in_valid_i <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clk_i);
    end
  endtask

  // Registers change only once the pipeline has drained.
  task automatic write_reg(input cfg_reg_e sel, input logic [CfgDataW-1:0] value);
    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= sel;
    cfg_data_i  <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cfg_writes++;
    case (sel)
      CFG_ORIGIN_X:     org_x = value;
      CFG_ORIGIN_Y:     org_y = value;
      CFG_IMAGE_WIDTH:  img_w = value[SizeW-1:0];
      CFG_IMAGE_HEIGHT: img_h = value[SizeW-1:0];
      CFG_DRAW_COLOR:   color = value[ColorW-1:0];
      default: ;
    endcase
  endtask

  task automatic check_field(input string name, input int unsigned want,
                             input int unsigned got);
    if (want != got) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #3000000;
    $display("FAILED: results differ");
    $finish;
  end

  // Receiver: short random stalls, and one long hold-off on request.
  initial begin : receiver
    logic hold_seen;
    hold_seen = 1'b0;
    out_stall_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_tog != hold_seen) begin
        hold_seen = hold_tog;
        out_stall_i <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end else if (!calm && $urandom_range(0, 9) == 0) begin
        out_stall_i <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : result_check
    fb_write_t want;
    if (rst_ni && in_valid_i && in_stall_o) input_stalls++;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_writes.size() == 0) begin
        mismatches++;
        $display("%0t: result with nothing expected, actual we %0b addr %0h data %0h done %0b",
                 $time, write_enable_o, write_address_o, write_data_o, image_done_o);
      end else begin
        want = pending_writes.pop_front();
        check_field("write_enable", want.we, write_enable_o);
        check_field("write_address", want.addr, write_address_o);
        check_field("write_data", want.data, write_data_o);
        check_field("image_done", want.done, image_done_o);
        if (image_done_o) images_done++;
        if (write_enable_o) writes_made++;
        else clipped++;
      end
    end
  end

  initial begin : stimulus
    int               n;
    int               phase;
    int               sel;
    int               ew;
    int               eh;
    logic [SizeW-1:0] w;
    logic [SizeW-1:0] h;
    rst_ni        <= 1'b0;
    in_valid_i    <= 1'b0;
    pixel_value_i <= '0;
    cfg_we_i      <= 1'b0;
    cfg_index_i   <= CFG_ORIGIN_X;
    cfg_data_i    <= '0;
    calm          <= 1'b0;
    hold_tog      <= 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < NDIR; i++) begin
      if (directed_rows[i].kind == ROW_REG)
        write_reg(directed_rows[i].sel, directed_rows[i].value);
      else
        send_pixel(directed_rows[i].pix, directed_rows[i].kind == ROW_KNOWN,
                   directed_rows[i].known);
    end

    phase = 0;
    while (items_sent < NUM_ITEMS) begin
      sel = $urandom_range(0, 99);
      if (phase == 1) begin
        w = 8'd8;
        h = 8'd4;
      end else if (sel < 4) begin
        w = 8'd0;
        h = 8'd1;
      end else if (sel < 8) begin
        w = 8'd1;
        h = 8'd0;
      end else if (sel < 11) begin
        w = 8'd255;
        h = 8'd1;
      end else if (sel < 14) begin
        w = 8'd1;
        h = 8'd255;
      end else if (sel < 18) begin
        w = SizeW'($urandom_range(9, 32));
        h = SizeW'($urandom_range(1, 4));
      end else begin
        w = SizeW'($urandom_range(1, 8));
        h = SizeW'($urandom_range(1, 8));
      end
      ew = (w == 0) ? 256 : int'(w);
      eh = (h == 0) ? 256 : int'(h);
      // Upper data bits of the size and color registers are junk on purpose.
      write_reg(CFG_IMAGE_WIDTH, {4'($urandom_range(0, 15)), w});
      write_reg(CFG_IMAGE_HEIGHT, {4'($urandom_range(0, 15)), h});
      write_reg(CFG_ORIGIN_X, pick_origin(ew, SCREEN_W));
      write_reg(CFG_ORIGIN_Y, pick_origin(eh, SCREEN_H));
      write_reg(CFG_DRAW_COLOR, CfgDataW'($urandom_range(0, 4095)));
      n = items_to_finish();
      // Some images are cut short or run over, so the next size change can land mid-image.
      if (phase != 1 && $urandom_range(0, 99) < 15) n = $urandom_range(1, n + 3);
      if (phase == 1) hold_tog <= ~hold_tog;
      for (int k = 0; k < n; k++) send_pixel(rand_pixel(), 1'b0, RES_NONE);
      phase++;
    end

    in_valid_i <= 1'b0;
    while (pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    $display("Run covered %0d pixel items over %0d image setups, %0d register writes.",
             items_sent, phase, cfg_writes);
    $display("Seen: %0d frame buffer writes, %0d clipped pixels, %0d images, %0d input stalls.",
             writes_made, clipped, images_done, input_stalls);
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
